@@ rtl/bblp_pkg.sv @@
package bblp_pkg;

  localparam int MAX_RADIUS   = 15;
  localparam int CHANNEL_BITS = 8;

  localparam int KS_W        = 5;
  localparam int RAD_W       = KS_W - 1;
  localparam int CNT_W       = KS_W;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int SUM_W       = CHANNEL_BITS + KS_W;
  localparam int RECIP_SH    = SUM_W + KS_W;
  localparam int RECIP_W     = RECIP_SH + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [KS_W-1:0] KS_RESET = KS_W'(3);

  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SH;

  // ceil(2^RECIP_SH / c), exact floor division for every window sum
  localparam longint unsigned RECIP_TBL [32] = '{
    RECIP_ONE,
    (RECIP_ONE +  0) /  1, (RECIP_ONE +  1) /  2, (RECIP_ONE +  2) /  3,
    (RECIP_ONE +  3) /  4, (RECIP_ONE +  4) /  5, (RECIP_ONE +  5) /  6,
    (RECIP_ONE +  6) /  7, (RECIP_ONE +  7) /  8, (RECIP_ONE +  8) /  9,
    (RECIP_ONE +  9) / 10, (RECIP_ONE + 10) / 11, (RECIP_ONE + 11) / 12,
    (RECIP_ONE + 12) / 13, (RECIP_ONE + 13) / 14, (RECIP_ONE + 14) / 15,
    (RECIP_ONE + 15) / 16, (RECIP_ONE + 16) / 17, (RECIP_ONE + 17) / 18,
    (RECIP_ONE + 18) / 19, (RECIP_ONE + 19) / 20, (RECIP_ONE + 20) / 21,
    (RECIP_ONE + 21) / 22, (RECIP_ONE + 22) / 23, (RECIP_ONE + 23) / 24,
    (RECIP_ONE + 24) / 25, (RECIP_ONE + 25) / 26, (RECIP_ONE + 26) / 27,
    (RECIP_ONE + 27) / 28, (RECIP_ONE + 28) / 29, (RECIP_ONE + 29) / 30,
    (RECIP_ONE + 30) / 31
  };

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [RECIP_W-1:0]      recip_t;

  typedef struct packed {
    sum_t             red_sum;
    sum_t             green_sum;
    sum_t             blue_sum;
    logic [CNT_W-1:0] count;
    logic             done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    FS_RUN,
    FS_FLUSH
  } front_state_t;

  function automatic recip_t recip_of(input logic [CNT_W-1:0] cnt);
    recip_of = RECIP_W'(RECIP_TBL[cnt]);
  endfunction

endpackage

@@ rtl/bblp_ifs.sv @@
interface bblp_pix_if import bblp_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  logic  line_end;

  modport source (output valid, red_in, green_in, blue_in, line_end, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, line_end, output ready);
endinterface

interface bblp_res_if import bblp_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  line_done;

  modport source (output valid, red_out, green_out, blue_out, line_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, line_done, output ready);
endinterface

interface bblp_cfg_if import bblp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KS_W-1:0] kernel_size;

  modport source (output valid, kernel_size, input ready);
  modport sink   (input valid, kernel_size, output ready);
endinterface

@@ rtl/box_blur_line_pass.sv @@
// One-dimensional box filter over a line of RGB pixels.
// in_ch: one pixel per beat, line_end high on the last pixel of a line.
// out_ch: one averaged pixel per line position, line_done on the last one.
// cfg_ch: writes kernel_size (window 2r+1, r = (kernel_size-1)/2); it also
//   drops any partial line. Write only while the block is idle; in_ch is
//   not ready while a cfg_ch beat is offered.
// Results lag the input by r pixels; the beat with line_end flushes the
// remaining positions (up to r), one per cycle while the job queue has room,
// during which in_ch is not ready. A result is registered in the job queue,
// then in the reciprocal multiply register at the queue pop, then in the
// output register, before out_ch offers it.
// The input takes one pixel per cycle while the queue has room and no
// flush is running; the front end emits at most one result per cycle
// into the queue, while it has room. A stalled out_ch fills the 4-entry job
// queue and then holds in_ch off; no beat is lost. Reset sets kernel_size
// to 3 and empties the window, the queue and the pipeline.
module box_blur_line_pass import bblp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bblp_pix_if.sink   in_ch,
  bblp_res_if.source out_ch,
  bblp_cfg_if.sink   cfg_ch
);

  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;
  q_status_t q_stat;

  bblp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_ch),
    .cfg      (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  bblp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  bblp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job    (pop_job),
    .q_stat (q_stat),
    .pop    (pop),
    .res    (out_ch)
  );

endmodule

@@ rtl/bblp_front.sv @@
module bblp_front import bblp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bblp_pix_if.sink     pix,
  bblp_cfg_if.sink     cfg,
  input  q_status_t    q_stat,
  output logic         push,
  output job_t         push_job
);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  pixel_t             store_r [STORE_DEPTH];
  pixel_t             old_px_r;
  logic [KS_W-1:0]    ks_r, ks_nxt;
  sum_t               red_sum_r, red_sum_nxt;
  sum_t               green_sum_r, green_sum_nxt;
  sum_t               blue_sum_r, blue_sum_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   lp_r, lp_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RAD_W-1:0]   right_r, right_nxt;
  front_state_t       state_r, state_nxt;

  logic               in_acc;
  logic               cfg_acc;
  logic               fl_go;
  logic               run_step;
  logic [RAD_W-1:0]   raw_rad;
  logic [RAD_W-1:0]   rad;
  logic [KS_W-1:0]    wlen;
  logic [KS_W:0]      fl_thr;
  logic               drop;
  pixel_t             old_px;
  pixel_t             add_px;
  pixel_t             sub_px;
  sum_t               red_new, green_new, blue_new;
  logic [CNT_W-1:0]   count_new;
  logic [CNT_W-1:0]   lp_new;
  logic [RAD_W-1:0]   rem;
  logic [PTR_W-1:0]   wr_inc;
  logic [PTR_W-1:0]   rd_inc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_acc  = pix.valid && pix.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign fl_go   = (state_r == FS_FLUSH) && !q_stat.full;
  assign run_step = in_acc && !cfg_acc;

  assign raw_rad = (ks_r == '0) ? '0 : RAD_W'((ks_r - 1'b1) >> 1);
  assign rad     = (int'(raw_rad) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : raw_rad;
  assign wlen    = {rad, 1'b1};
  assign fl_thr  = (KS_W+1)'(rad) + (KS_W+1)'(right_r) + 1'b1;

  assign old_px = old_px_r;
  assign drop   = (state_r == FS_RUN) ? (count_r >= wlen) : ({1'b0, count_r} >= fl_thr);
  assign sub_px = drop ? old_px : '0;
  assign add_px = (state_r == FS_RUN) ? pixel_t'{pix.red_in, pix.green_in, pix.blue_in} : '0;

  assign red_new   = red_sum_r   - SUM_W'(sub_px.red)   + SUM_W'(add_px.red);
  assign green_new = green_sum_r - SUM_W'(sub_px.green) + SUM_W'(add_px.green);
  assign blue_new  = blue_sum_r  - SUM_W'(sub_px.blue)  + SUM_W'(add_px.blue);
  assign count_new = count_r - CNT_W'(drop) + CNT_W'(state_r == FS_RUN);
  assign lp_new    = (lp_r < wlen) ? lp_r + 1'b1 : lp_r;
  assign rem       = (lp_new < {1'b0, rad}) ? RAD_W'(lp_new) : rad;
  assign wr_inc    = ptr_inc(wr_ptr_r);
  assign rd_inc    = ptr_inc(rd_ptr_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_RUN: begin
        if (run_step && pix.line_end && rad != '0) begin
          state_nxt = FS_FLUSH;
        end
      end
      FS_FLUSH: begin
        if (fl_go && right_r == RAD_W'(1)) begin
          state_nxt = FS_RUN;
        end
      end
      default: state_nxt = FS_RUN;
    endcase
  end

  always_comb begin
    pix.ready     = (state_r == FS_RUN) && !q_stat.full && !cfg.valid;
    cfg.ready     = (state_r == FS_RUN);
    push          = 1'b0;
    push_job      = '{red_sum: red_new, green_sum: green_new, blue_sum: blue_new,
                      count: count_new, done: 1'b0};
    ks_nxt        = ks_r;
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    count_nxt     = count_r;
    lp_nxt        = lp_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    right_nxt     = right_r;
    if (cfg_acc) begin
      ks_nxt        = cfg.kernel_size;
      red_sum_nxt   = '0;
      green_sum_nxt = '0;
      blue_sum_nxt  = '0;
      count_nxt     = '0;
      lp_nxt        = '0;
      rd_ptr_nxt    = wr_ptr_r;
    end else if (in_acc) begin
      push          = lp_new > {1'b0, rad};
      push_job.done = pix.line_end && rad == '0;
      red_sum_nxt   = red_new;
      green_sum_nxt = green_new;
      blue_sum_nxt  = blue_new;
      count_nxt     = count_new;
      lp_nxt        = lp_new;
      wr_ptr_nxt    = wr_inc;
      rd_ptr_nxt    = drop ? rd_inc : rd_ptr_r;
      right_nxt     = rem;
      if (pix.line_end && rad == '0) begin
        red_sum_nxt   = '0;
        green_sum_nxt = '0;
        blue_sum_nxt  = '0;
        count_nxt     = '0;
        lp_nxt        = '0;
        rd_ptr_nxt    = wr_inc;
      end
    end else if (fl_go) begin
      push          = 1'b1;
      push_job.done = right_r == RAD_W'(1);
      red_sum_nxt   = red_new;
      green_sum_nxt = green_new;
      blue_sum_nxt  = blue_new;
      count_nxt     = count_new;
      rd_ptr_nxt    = drop ? rd_inc : rd_ptr_r;
      right_nxt     = right_r - 1'b1;
      if (right_r == RAD_W'(1)) begin
        red_sum_nxt   = '0;
        green_sum_nxt = '0;
        blue_sum_nxt  = '0;
        count_nxt     = '0;
        lp_nxt        = '0;
        rd_ptr_nxt    = wr_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_RUN;
      ks_r        <= KS_RESET;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      count_r     <= '0;
      lp_r        <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      right_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ks_r        <= ks_nxt;
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      count_r     <= count_nxt;
      lp_r        <= lp_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      right_r     <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_step) begin
      store_r[wr_ptr_r] <= pixel_t'{pix.red_in, pix.green_in, pix.blue_in};
    end
    // prefetch the oldest pixel, forward the beat being written
    if (run_step && rd_ptr_nxt == wr_ptr_r) begin
      old_px_r <= add_px;
    end else begin
      old_px_r <= store_r[rd_ptr_nxt];
    end
  end

  ap_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wlen)
    else $error("window count exceeds window length");

  ap_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("empty window with read and write pointers apart");

  ap_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FS_FLUSH |-> (right_r != '0 && right_r <= rad))
    else $error("flush counter out of range");

  ap_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

endmodule

@@ rtl/bblp_queue.sv @@
module bblp_queue import bblp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t stat
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

@@ rtl/bblp_back.sv @@
module bblp_back import bblp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  q_status_t  q_stat,
  output logic       pop,
  bblp_res_if.source res
);

  logic              a_valid_r;
  logic [PROD_W-1:0] a_red_r;
  logic [PROD_W-1:0] a_green_r;
  logic [PROD_W-1:0] a_blue_r;
  logic              a_done_r;
  logic              out_valid_r;
  chan_t             out_red_r;
  chan_t             out_green_r;
  chan_t             out_blue_r;
  logic              out_done_r;

  logic              out_load;
  logic              a_take;
  logic [PROD_W-1:0] recip_ext;

  assign out_load  = !out_valid_r || res.ready;
  assign a_take    = !a_valid_r || out_load;
  assign pop       = a_take && !q_stat.empty;
  assign recip_ext = PROD_W'(recip_of(job.count));

  assign res.valid     = out_valid_r;
  assign res.red_out   = out_red_r;
  assign res.green_out = out_green_r;
  assign res.blue_out  = out_blue_r;
  assign res.line_done = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_r <= !q_stat.empty;
      end
      if (out_load) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_red_r   <= PROD_W'(job.red_sum)   * recip_ext;
      a_green_r <= PROD_W'(job.green_sum) * recip_ext;
      a_blue_r  <= PROD_W'(job.blue_sum)  * recip_ext;
      a_done_r  <= job.done;
    end
    if (out_load && a_valid_r) begin
      out_red_r   <= CHANNEL_BITS'(a_red_r   >> RECIP_SH);
      out_green_r <= CHANNEL_BITS'(a_green_r >> RECIP_SH);
      out_blue_r  <= CHANNEL_BITS'(a_blue_r  >> RECIP_SH);
      out_done_r  <= a_done_r;
    end
  end

endmodule

@@ dv/box_blur_line_pass_tb.sv @@
module box_blur_line_pass_tb;
  import bblp_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } pixel_t;

  class line_blur_predictor;
    pixel_t           ring [STORE_DEPTH];
    sum_t             red_acc;
    sum_t             green_acc;
    sum_t             blue_acc;
    logic [CNT_W-1:0] win_cnt;
    logic [5:0]       line_pos;
    logic [PTR_W-1:0] wr_idx;
    logic [KS_W-1:0]  ksize;
    pixel_t           avg_q [$];
    int               mismatches;

    function new();
      ksize      = KS_RESET;
      wr_idx     = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      red_acc   = '0;
      green_acc = '0;
      blue_acc  = '0;
      win_cnt   = '0;
      line_pos  = '0;
    endfunction

    function void set_kernel(logic [KS_W-1:0] ks);
      ksize = ks;
      clear_line();
    endfunction

    function int radius();
      int r;
      r = (ksize == 0) ? 0 : (int'(ksize) - 1) / 2;
      return (r > MAX_RADIUS) ? MAX_RADIUS : r;
    endfunction

    function void drop_oldest();
      int idx;
      if (win_cnt == 0) return;
      idx = (int'(wr_idx) + STORE_DEPTH - int'(win_cnt)) % STORE_DEPTH;
      red_acc   = red_acc - sum_t'(ring[idx].red);
      green_acc = green_acc - sum_t'(ring[idx].green);
      blue_acc  = blue_acc - sum_t'(ring[idx].blue);
      win_cnt   = win_cnt - 1'b1;
    endfunction

    function void push_avg(logic done);
      int     c;
      pixel_t e;
      c       = (win_cnt == 0) ? 1 : int'(win_cnt);
      e.red   = chan_t'(int'(red_acc) / c);
      e.green = chan_t'(int'(green_acc) / c);
      e.blue  = chan_t'(int'(blue_acc) / c);
      e.last  = done;
      avg_q.push_back(e);
    endfunction

    function void note_pixel(pixel_t p);
      int r;
      int wlen;
      int rem;
      r    = radius();
      wlen = 2 * r + 1;
      if (int'(win_cnt) >= wlen) drop_oldest();
      ring[wr_idx] = p;
      red_acc      = red_acc + sum_t'(p.red);
      green_acc    = green_acc + sum_t'(p.green);
      blue_acc     = blue_acc + sum_t'(p.blue);
      wr_idx       = PTR_W'((int'(wr_idx) + 1) % STORE_DEPTH);
      win_cnt      = win_cnt + 1'b1;
      if (int'(line_pos) < wlen) line_pos = line_pos + 1'b1;
      if (int'(line_pos) > r) push_avg(p.last && r == 0);
      if (p.last) begin
        rem = (int'(line_pos) < r) ? int'(line_pos) : r;
        // flush the right edge; each step drops at most one pixel
        for (int k = 1; k <= rem; k++) begin
          if (int'(win_cnt) >= r + (rem - k + 1) + 1) drop_oldest();
          push_avg(k == rem);
        end
        clear_line();
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (avg_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: r=%0d g=%0d b=%0d done=%0b",
                   got.red, got.green, got.blue, got.last);
        return;
      end
      want = avg_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected r=%0d g=%0d b=%0d done=%0b,",
                    " got r=%0d g=%0d b=%0d done=%0b"},
                   want.red, want.green, want.blue, want.last,
                   got.red, got.green, got.blue, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bblp_pix_if pix_bus ();
  bblp_res_if res_bus ();
  bblp_cfg_if cfg_bus ();

  box_blur_line_pass i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  line_blur_predictor blur_sb;
  int                 px_accepted;
  int                 burst_left;
  bit                 hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("** box_blur_line_pass: FAILED **");
    $finish;
  end

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 5))
      0: return chan_t'(0);
      1: return chan_t'(255);
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input pixel_t p);
    pix_bus.valid    <= 1'b1;
    pix_bus.red_in   <= p.red;
    pix_bus.green_in <= p.green;
    pix_bus.blue_in  <= p.blue;
    pix_bus.line_end <= p.last;
    do @(posedge clk); while (!pix_bus.ready);
    blur_sb.note_pixel(p);
    px_accepted++;
  endtask

  task automatic pace(input bit steady);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, 8);
      if (!steady && gap > 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_line(input int len, input bit steady, input bit closed);
    pixel_t p;
    for (int i = 0; i < len; i++) begin
      p.red   = pick_chan();
      p.green = pick_chan();
      p.blue  = pick_chan();
      p.last  = closed && (i == len - 1);
      pace(steady);
      send_pixel(p);
    end
  endtask

  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (blur_sb.avg_q.size() != 0) @(posedge clk);
    // cover beats that are still in the pipeline without a result
    repeat (8) @(posedge clk);
  endtask

  task automatic write_kernel(input logic [KS_W-1:0] ks);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.kernel_size <= ks;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    blur_sb.set_kernel(ks);
  endtask

  initial begin : receiver
    int mode;
    int seg_left;
    seg_left = 0;
    mode     = 0;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && px_accepted >= 120) begin
        // hold off long enough to fill the job queue and stall the input
        res_bus.ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        case (mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= ($urandom_range(0, 3) != 0);
          2: res_bus.ready <= ($urandom_range(0, 1) != 0);
          default: res_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : monitor
    pixel_t got;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        got = '{res_bus.red_out, res_bus.green_out, res_bus.blue_out, res_bus.line_done};
        blur_sb.check_pixel(got);
      end
    end
  end

  initial begin : stimulus
    int ks_plan [12];
    int ks;
    int r;
    int sent;
    int len;
    ks_plan = '{31, 0, 5, 1, 16, 2, 7, 30, 3, 12, 9, 31};
    blur_sb     = new();
    px_accepted = 0;
    burst_left  = 0;
    hold_done   = 1'b0;

    rst_n               <= 1'b0;
    pix_bus.valid       <= 1'b0;
    pix_bus.red_in      <= '0;
    pix_bus.green_in    <= '0;
    pix_bus.blue_in     <= '0;
    pix_bus.line_end    <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.kernel_size <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset kernel: extremes of every channel
    send_pixel('{8'hFF, 8'h00, 8'hFF, 1'b0});
    send_pixel('{8'h00, 8'hFF, 8'h00, 1'b0});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_pixel('{8'h00, 8'h00, 8'h00, 1'b0});
    send_pixel('{8'hAA, 8'h55, 8'h0F, 1'b1});
    send_pixel('{8'hF0, 8'h33, 8'hCC, 1'b1});
    wait_idle();
    // zero kernel acts as one
    write_kernel(KS_W'(0));
    send_pixel('{8'h01, 8'hFE, 8'h80, 1'b0});
    send_pixel('{8'h7F, 8'h02, 8'hFF, 1'b1});
    wait_idle();
    write_kernel(KS_W'(1));
    send_pixel('{8'hFF, 8'hFF, 8'h00, 1'b1});
    wait_idle();
    // even kernel rounds the radius down
    write_kernel(KS_W'(2));
    send_pixel('{8'h10, 8'h20, 8'h30, 1'b0});
    send_pixel('{8'hFF, 8'h00, 8'h80, 1'b0});
    send_pixel('{8'h00, 8'hFF, 8'h7F, 1'b1});
    wait_idle();
    // widest window, line shorter than the radius
    write_kernel(KS_W'(31));
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_pixel('{8'h00, 8'h01, 8'h02, 1'b0});
    send_pixel('{8'hFE, 8'h00, 8'hFF, 1'b1});
    // partial line, then drop it with a register write
    send_pixel('{8'h55, 8'hAA, 8'h55, 1'b0});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    wait_idle();
    write_kernel(KS_W'(4));
    send_pixel('{8'h00, 8'hFF, 8'h00, 1'b0});
    send_pixel('{8'hFF, 8'h00, 8'hFF, 1'b0});
    send_pixel('{8'h80, 8'h80, 8'h80, 1'b0});
    send_pixel('{8'h01, 8'h02, 8'h03, 1'b1});
    wait_idle();

    for (int ph = 0; ph < 14; ph++) begin
      ks = (ph < 12) ? ks_plan[ph] : $urandom_range(0, 31);
      r  = (ks == 0) ? 0 : (ks - 1) / 2;
      write_kernel(KS_W'(ks));
      sent = 0;
      while (sent < 14) begin
        if ($urandom_range(0, 9) == 0)
          len = $urandom_range(2 * r + 2, 2 * r + 40);
        else
          len = $urandom_range(1, 2 * r + 4);
        send_line(len, $urandom_range(0, 3) == 0, 1'b1);
        sent += len;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (blur_sb.mismatches == 0 && blur_sb.avg_q.size() == 0)
      $display("** box_blur_line_pass: PASSED **");
    else
      $display("** box_blur_line_pass: FAILED **");
    $finish;
  end

endmodule
